@@ rtl/key_matrix_debouncer_unit_macros.svh @@
// Assertion helpers for the key matrix debouncer.
// Both macros expect clk and arst_n in scope.
`ifndef KEY_MATRIX_DEBOUNCER_UNIT_MACROS_SVH
`define KEY_MATRIX_DEBOUNCER_UNIT_MACROS_SVH

// same-cycle implication
`define KMD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KMD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/kmd_pkg.sv @@
package kmd_pkg;

	localparam int ROW_W  = 3;
	localparam int COL_W  = 16;
	localparam int CNT_W  = 8;
	localparam int PCNT_W = 7;
	localparam int POP_W  = 5;

	localparam logic [CNT_W-1:0]  RELOAD_RST = 8'd5;
	localparam logic [PCNT_W-1:0] PCNT_MAX   = 7'h7F;

	// one scanned row, packed as on the input stream
	typedef struct packed {
		logic [COL_W-1:0] column_lines;
		logic [ROW_W-1:0] row_index;
	} item_t;

	// one result, packed as on the output stream
	typedef struct packed {
		logic [PCNT_W-1:0] pressed_count;
		logic              settled;
		logic [COL_W-1:0]  stable_row;
	} res_t;

	// bit count of one nibble
	function automatic logic [2:0] pop4(input logic [3:0] v);
		logic [2:0] n;
		case (v)
			4'h0: n = 3'd0;
			4'h1, 4'h2, 4'h4, 4'h8: n = 3'd1;
			4'h3, 4'h5, 4'h6, 4'h9, 4'hA, 4'hC: n = 3'd2;
			4'h7, 4'hB, 4'hD, 4'hE: n = 3'd3;
			4'hF: n = 3'd4;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	// bit count of a row: four nibble lookups summed
	function automatic logic [POP_W-1:0] popcnt16(input logic [COL_W-1:0] v);
		logic [POP_W-1:0] s;
		s = '0;
		for (int i = 0; i < COL_W / 4; i++) begin
			s = s + POP_W'(pop4(v[i*4 +: 4]));
		end
		return s;
	endfunction

endpackage

@@ rtl/kmd_in_reg.sv @@
module kmd_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  kmd_pkg::item_t item_d,
	input  logic          adv,
	output logic          valid_s1,
	output kmd_pkg::item_t item_s1
);
	import kmd_pkg::*;

	// register is free when empty or draining this cycle
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload capture on accepted request
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_d;
		end
	end

endmodule

@@ rtl/kmd_update.sv @@
module kmd_update #(
	parameter int ROWS = 5,
	parameter int COLS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  kmd_pkg::item_t            item,
	input  logic [kmd_pkg::CNT_W-1:0] reload,
	output kmd_pkg::res_t             res_d
);
	import kmd_pkg::*;

	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int TW = $clog2(ROWS * COL_W + 1);
	localparam int EC = (COLS < COL_W) ? COLS : COL_W;
	localparam logic [COL_W-1:0] COL_MASK = COL_W'((32'd1 << EC) - 32'd1);
	localparam logic [31:0] LAST_ROW = 32'(ROWS - 1);

	// debounce state
	logic [COL_W-1:0] pend_q [ROWS];
	logic [POP_W-1:0] pcnt_q [ROWS];
	logic [COL_W-1:0] stab_q [ROWS];
	logic [CNT_W-1:0] cnt_q;
	logic [TW-1:0]    ptot_q;
	logic [TW-1:0]    stot_q;

	logic [31:0]      row_ext;
	logic             in_range;
	logic             is_last;
	logic [RW-1:0]    ridx;
	logic [COL_W-1:0] pressed;
	logic [COL_W-1:0] pend_cur;
	logic [POP_W-1:0] pcnt_cur;
	logic [COL_W-1:0] stab_cur;
	logic [POP_W-1:0] pop_new;
	logic             changed;
	logic [CNT_W-1:0] reload_eff;
	logic [CNT_W-1:0] cnt_a;
	logic             dec;
	logic [CNT_W-1:0] cnt_d;
	logic             copy;
	logic [TW-1:0]    ptot_d;
	logic [TW-1:0]    stot_d;

	// row decode and pending compare
	always_comb begin
		row_ext  = 32'(item.row_index);
		in_range = row_ext < 32'(ROWS);
		is_last  = row_ext == LAST_ROW;
		ridx     = row_ext[RW-1:0];
		pressed  = ~item.column_lines & COL_MASK;
		pend_cur = in_range ? pend_q[ridx] : '0;
		pcnt_cur = in_range ? pcnt_q[ridx] : '0;
		stab_cur = in_range ? stab_q[ridx] : '0;
		pop_new  = popcnt16(pressed);
		changed  = in_range && (pressed != pend_cur);
	end

	// shared counter: reload on change, count down at end of scan
	always_comb begin
		reload_eff = (reload == '0) ? CNT_W'(1) : reload;
		cnt_a      = changed ? reload_eff : cnt_q;
		dec        = in_range && is_last && (cnt_a != '0);
		cnt_d      = dec ? cnt_a - CNT_W'(1) : cnt_a;
		copy       = dec && (cnt_d == '0);
	end

	// running key totals, pending and stable
	always_comb begin
		ptot_d = changed ? (ptot_q - TW'(pcnt_cur) + TW'(pop_new)) : ptot_q;
		stot_d = copy ? ptot_d : stot_q;
	end

	// result for this request
	always_comb begin
		if (!in_range) begin
			res_d.stable_row = '0;
		end else if (copy) begin
			res_d.stable_row = pressed;
		end else begin
			res_d.stable_row = stab_cur;
		end
		res_d.settled = (cnt_d == '0);
		if (32'(stot_d) > 32'(PCNT_MAX)) begin
			res_d.pressed_count = PCNT_MAX;
		end else begin
			res_d.pressed_count = PCNT_W'(stot_d);
		end
	end

	// state update; copy moves every pending row to stable at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROWS; i++) begin
				pend_q[i] <= '0;
				pcnt_q[i] <= '0;
				stab_q[i] <= '0;
			end
			cnt_q  <= RELOAD_RST;
			ptot_q <= '0;
			stot_q <= '0;
		end else if (en) begin
			for (int i = 0; i < ROWS; i++) begin
				if (changed && (ridx == RW'(i))) begin
					pend_q[i] <= pressed;
					pcnt_q[i] <= pop_new;
				end
				if (copy) begin
					stab_q[i] <= (changed && (ridx == RW'(i))) ? pressed : pend_q[i];
				end
			end
			cnt_q  <= cnt_d;
			ptot_q <= ptot_d;
			stot_q <= stot_d;
		end
	end

endmodule

@@ rtl/kmd_out_reg.sv @@
module kmd_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  kmd_pkg::res_t res_d,
	input  logic          m_tready,
	output logic          m_tvalid,
	output kmd_pkg::res_t res_q
);
	import kmd_pkg::*;

	// result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

endmodule

@@ rtl/key_matrix_debouncer_unit.sv @@
// A request accepted into the input register moves through the update logic into the output register, raising m_tvalid.
// Throughput: one row per cycle while results are taken; input register, update logic, output register.
// A waiting result blocks the input only once the input register also holds a row.
// Reset (arst_n low, asynchronous): pending and stable matrices clear,
// debounce counter and reload register go to 5, both stream registers empty.
`include "key_matrix_debouncer_unit_macros.svh"

module key_matrix_debouncer_unit #(
	parameter int ROWS = 5,
	parameter int COLS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [2:0] row_index, [18:3] column_lines, [23:19] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [15:0] stable_row, [16] settled, [23:17] pressed_count
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data   // debounce_reload
);
	import kmd_pkg::*;

	logic             valid_s1;
	item_t            item_d;
	item_t            item_s1;
	logic             adv;
	res_t             res_d;
	res_t             res_q;
	logic [CNT_W-1:0] reload_q;

	assign item_d = item_t'(s_tdata[ROW_W+COL_W-1:0]);

	// stage advances when the output slot is free or being emptied
	assign adv = valid_s1 && (!m_tvalid || m_tready);

	// reload register, written any time
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= RELOAD_RST;
		end else if (cfg_valid) begin
			reload_q <= cfg_data;
		end
	end

	kmd_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.item_d   (item_d),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	kmd_update #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_upd (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (item_s1),
		.reload (reload_q),
		.res_d  (res_d)
	);

	kmd_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv),
		.res_d    (res_d),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.res_q    (res_q)
	);

	assign m_tdata = res_q;

	// checks
	`KMD_ASSERT_NEXT(a_adv_gives_result, adv, m_tvalid, "advanced row produced no result")
	`KMD_ASSERT_NOW(a_stall_only_when_full, !s_tready, valid_s1 && m_tvalid && !m_tready, "input stalled with free space")
	`KMD_ASSERT_NEXT(a_accept_fills_s1, s_tvalid && s_tready, valid_s1, "accepted request lost in input register")

endmodule

@@ tb/testbench.sv @@
module testbench;
	import kmd_pkg::*;

	localparam int ROWS = 5;
	localparam int COLS = 16;
	localparam logic [COL_W-1:0] COL_MASK = (COLS >= COL_W) ? '1 : COL_W'((1 << COLS) - 1);
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 4;

	// Debounced key matrix as the block should see it, plus the reports still due
	class debounced_matrix;
		logic [COL_W-1:0] pending_keys[ROWS];
		logic [COL_W-1:0] stable_keys[ROWS];
		logic [CNT_W-1:0] scan_countdown;
		logic [CNT_W-1:0] reload_value;
		res_t             reports_due[$];
		int               mismatches;

		function new();
			for (int i = 0; i < ROWS; i++) begin
				pending_keys[i] = '0;
				stable_keys[i] = '0;
			end
			scan_countdown = RELOAD_RST;
			reload_value = RELOAD_RST;
			mismatches = 0;
		endfunction

		function void set_reload(input logic [CNT_W-1:0] v);
			reload_value = v;
		endfunction

		function int due();
			return reports_due.size();
		endfunction

		// one accepted row request: update the matrix and queue its report
		function void take_scan_row(input item_t it);
			logic [COL_W-1:0] bits;
			res_t             rpt;
			int               total;
			bits = ~it.column_lines & COL_MASK;
			rpt.stable_row = '0;
			if (it.row_index < ROWS) begin
				if (bits != pending_keys[it.row_index]) begin
					pending_keys[it.row_index] = bits;
					scan_countdown = (reload_value == 0) ? CNT_W'(1) : reload_value;
				end
				// end of scan: count down, copy the whole matrix on reaching zero
				if (it.row_index == ROWS - 1 && scan_countdown != 0) begin
					scan_countdown = scan_countdown - 1'b1;
					if (scan_countdown == 0) begin
						for (int i = 0; i < ROWS; i++)
							stable_keys[i] = pending_keys[i];
					end
				end
				rpt.stable_row = stable_keys[it.row_index];
			end
			rpt.settled = (scan_countdown == 0);
			total = 0;
			for (int i = 0; i < ROWS; i++)
				total += $countones(stable_keys[i]);
			rpt.pressed_count = (total > PCNT_MAX) ? PCNT_MAX : PCNT_W'(total);
			reports_due.push_back(rpt);
		endfunction

		function void check_report(input res_t got);
			res_t want;
			if (reports_due.size() == 0) begin
				$error("report with no row request waiting: %h", got);
				mismatches++;
				return;
			end
			want = reports_due.pop_front();
			if (got.stable_row !== want.stable_row) begin
				$error("stable_row: expected %h, got %h", want.stable_row, got.stable_row);
				mismatches++;
			end
			if (got.settled !== want.settled) begin
				$error("settled: expected %0d, got %0d", want.settled, got.settled);
				mismatches++;
			end
			if (got.pressed_count !== want.pressed_count) begin
				$error("pressed_count: expected %0d, got %0d",
					want.pressed_count, got.pressed_count);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // [2:0] row_index, [18:3] column_lines, [23:19] zero
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // [15:0] stable_row, [16] settled, [23:17] pressed_count
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;

	debounced_matrix  keys_seen = new;
	logic [COL_W-1:0] held_keys[ROWS];
	int               idle_pct = 12;
	bit               idling_allowed = 1'b1;
	int               hold_off_cycles = 0;
	int               quiet_cycles = 0;

	key_matrix_debouncer_unit #(
		.ROWS(ROWS),
		.COLS(COLS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result side: random stall bursts, plus a long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				m_tready <= 1'b0;
				hold_off_cycles--;
			end else begin
				if (stall_left == 0 && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
					stall_left = $urandom_range(1, 17);
				if (stall_left > 0) begin
					m_tready <= 1'b0;
					stall_left--;
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	// result check
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			keys_seen.check_report(res_t'(m_tdata[$bits(res_t)-1:0]));
	end

	// watchdog: too long without any handshake on input, result or config
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// offer one row, wait for it to be taken
	task automatic send_row(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] cols);
		item_t it;
		it.row_index = row;
		it.column_lines = cols;
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= 24'(it);
		do @(posedge clk); while (!s_tready);
		keys_seen.take_scan_row(it);
	endtask

	// stop offering and let every report come back
	task automatic drain_block();
		s_tvalid <= 1'b0;
		while (keys_seen.due() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reload(input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		keys_seen.set_reload(v);
	endtask

	// well-formed scans of a slowly changing matrix, with bounce and stray rows
	task automatic run_scans(input int rows_wanted);
		int               sent;
		int               first;
		int               r;
		logic [COL_W-1:0] cols;
		sent = 0;
		while (sent < rows_wanted) begin
			if (idling_allowed && $urandom_range(0, 7) == 0)
				idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 25);
			if ($urandom_range(0, 3) == 0) begin
				r = $urandom_range(0, ROWS - 1);
				held_keys[r] ^= COL_W'(1) << $urandom_range(0, COL_W - 1);
			end
			if ($urandom_range(0, 15) == 0)
				held_keys[$urandom_range(0, ROWS - 1)] = COL_W'($urandom);
			// now and then a scan starts part way through
			first = ($urandom_range(0, 9) == 0) ? $urandom_range(1, ROWS - 1) : 0;
			for (int i = first; i < ROWS; i++) begin
				if ($urandom_range(0, 24) == 0)
					send_row(ROW_W'($urandom_range(ROWS, 7)), COL_W'($urandom));
				if ($urandom_range(0, 39) == 0) begin
					send_row(ROW_W'($urandom_range(0, ROWS - 1)), COL_W'($urandom));
					sent++;
				end
				cols = ~held_keys[i];
				if ($urandom_range(0, 19) == 0)
					cols ^= COL_W'($urandom);
				send_row(ROW_W'(i), cols);
				sent++;
			end
		end
	endtask

	// stimulus
	initial begin
		logic [COL_W-1:0] scan_mixed[ROWS];
		logic [COL_W-1:0] scan_changed[ROWS];
		scan_mixed = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'hFFFE};
		scan_changed = '{16'h0000, 16'h7FFF, 16'hAAAA, 16'h5555, 16'h0000};
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero reload acts as one, so every changed scan settles at once
		write_reload(8'd0);
		for (int i = 0; i < ROWS; i++)
			send_row(ROW_W'(i), scan_mixed[i]);
		send_row(3'd5, 16'h1234);
		send_row(3'd7, 16'hFFFF);
		send_row(3'd6, 16'h0000);
		for (int i = 0; i < ROWS; i++)
			send_row(ROW_W'(i), scan_changed[i]);
		for (int i = 0; i < ROWS; i++)
			send_row(ROW_W'(i), 16'h0000);
		for (int i = 0; i < ROWS; i++)
			send_row(ROW_W'(i), 16'hFFFF);
		drain_block();

		for (int i = 0; i < ROWS; i++)
			held_keys[i] = COL_W'($urandom);

		write_reload(8'd1);
		run_scans(72);
		drain_block();

		// largest reload, and a long result stall so the input backs up
		write_reload(8'd255);
		hold_off_cycles = 80;
		run_scans(72);
		drain_block();

		// sender waits for every report half way
		write_reload(8'd3);
		run_scans(36);
		s_tvalid <= 1'b0;
		while (keys_seen.due() != 0) @(posedge clk);
		run_scans(36);
		drain_block();

		write_reload(8'($urandom_range(2, 8)));
		run_scans(72);
		drain_block();

		// closing stretch without idling
		idling_allowed = 1'b0;
		idle_pct = 0;
		write_reload(8'd2);
		run_scans(72);
		drain_block();
		repeat (8) @(posedge clk);

		if (keys_seen.mismatches == 0 && keys_seen.due() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
